/* src/hesd_pkg.sv */
// shared types, constants, name table and utf-8 encoder for the entity decoder
package hesd_pkg;

  localparam int unsigned MAX_BODY_DEF   = 8;
  localparam int unsigned FIFO_DEPTH_DEF = 2;

  localparam logic [20:0] CODE_LIMIT = 21'h10FFFF;
  localparam logic [20:0] CODE_SAT   = 21'h110000;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_HASH = 8'h23;

  typedef enum logic [1:0] {
    TK_NONE,
    TK_BYTE,
    TK_CODE,
    TK_NAME
  } tail_kind_e;

  typedef struct packed {
    tail_kind_e  kind;
    logic [20:0] val;
    logic        text_end;
  } cmd_ctl_t;

  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] b;
  } utf8_t;

  function automatic utf8_t utf8_enc(input logic [20:0] cp);
    utf8_t r;
    r.b = '0;
    if (cp < 21'h80) begin
      r.len  = 3'd1;
      r.b[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      r.len  = 3'd2;
      r.b[0] = {3'b110, cp[10:6]};
      r.b[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      r.len  = 3'd3;
      r.b[0] = {4'b1110, cp[15:12]};
      r.b[1] = {2'b10, cp[11:6]};
      r.b[2] = {2'b10, cp[5:0]};
    end else begin
      r.len  = 3'd4;
      r.b[0] = {5'b11110, cp[20:18]};
      r.b[1] = {2'b10, cp[17:12]};
      r.b[2] = {2'b10, cp[11:6]};
      r.b[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

  // key holds the name right-aligned, zero-padded on the left
  function automatic logic [15:0] name_cp(input logic [63:0] key);
    logic [15:0] cp;
    case (key)
      "amp": cp = 16'd38;  "lt": cp = 16'd60;  "gt": cp = 16'd62;
      "Agrave": cp = 16'd192;  "Aacute": cp = 16'd193;  "Acirc": cp = 16'd194;
      "Atilde": cp = 16'd195;  "Auml": cp = 16'd196;  "Aring": cp = 16'd197;
      "AElig": cp = 16'd198;  "Ccedil": cp = 16'd199;  "Egrave": cp = 16'd200;
      "Eacute": cp = 16'd201;  "Ecirc": cp = 16'd202;  "Euml": cp = 16'd203;
      "Igrave": cp = 16'd204;  "Iacute": cp = 16'd205;  "Icirc": cp = 16'd206;
      "Iuml": cp = 16'd207;  "ETH": cp = 16'd208;  "Ntilde": cp = 16'd209;
      "Ograve": cp = 16'd210;  "Oacute": cp = 16'd211;  "Ocirc": cp = 16'd212;
      "Otilde": cp = 16'd213;  "Ouml": cp = 16'd214;  "Oslash": cp = 16'd216;
      "Ugrave": cp = 16'd217;  "Uacute": cp = 16'd218;  "Ucirc": cp = 16'd219;
      "Uuml": cp = 16'd220;  "Yacute": cp = 16'd221;  "THORN": cp = 16'd222;
      "szlig": cp = 16'd223;  "agrave": cp = 16'd224;  "aacute": cp = 16'd225;
      "acirc": cp = 16'd226;  "atilde": cp = 16'd227;  "auml": cp = 16'd228;
      "aring": cp = 16'd229;  "aelig": cp = 16'd230;  "ccedil": cp = 16'd231;
      "egrave": cp = 16'd232;  "eacute": cp = 16'd233;  "ecirc": cp = 16'd234;
      "euml": cp = 16'd235;  "igrave": cp = 16'd236;  "iacute": cp = 16'd237;
      "icirc": cp = 16'd238;  "iuml": cp = 16'd239;  "eth": cp = 16'd240;
      "ntilde": cp = 16'd241;  "ograve": cp = 16'd242;  "oacute": cp = 16'd243;
      "ocirc": cp = 16'd244;  "otilde": cp = 16'd245;  "ouml": cp = 16'd246;
      "oslash": cp = 16'd248;  "ugrave": cp = 16'd249;  "uacute": cp = 16'd250;
      "ucirc": cp = 16'd251;  "uuml": cp = 16'd252;  "yacute": cp = 16'd253;
      "thorn": cp = 16'd254;  "yuml": cp = 16'd255;  "nbsp": cp = 16'd160;
      "iexcl": cp = 16'd161;  "cent": cp = 16'd162;  "pound": cp = 16'd163;
      "curren": cp = 16'd164;  "yen": cp = 16'd165;  "brvbar": cp = 16'd166;
      "sect": cp = 16'd167;  "uml": cp = 16'd168;  "copy": cp = 16'd169;
      "ordf": cp = 16'd170;  "laquo": cp = 16'd171;  "not": cp = 16'd172;
      "shy": cp = 16'd173;  "reg": cp = 16'd174;  "macr": cp = 16'd175;
      "deg": cp = 16'd176;  "plusmn": cp = 16'd177;  "sup2": cp = 16'd178;
      "sup3": cp = 16'd179;  "acute": cp = 16'd180;  "micro": cp = 16'd181;
      "para": cp = 16'd182;  "cedil": cp = 16'd184;  "sup1": cp = 16'd185;
      "ordm": cp = 16'd186;  "raquo": cp = 16'd187;  "frac14": cp = 16'd188;
      "frac12": cp = 16'd189;  "frac34": cp = 16'd190;  "iquest": cp = 16'd191;
      "times": cp = 16'd215;  "divide": cp = 16'd247;  "forall": cp = 16'd8704;
      "part": cp = 16'd8706;  "exist": cp = 16'd8707;  "empty": cp = 16'd8709;
      "nabla": cp = 16'd8711;  "isin": cp = 16'd8712;  "notin": cp = 16'd8713;
      "ni": cp = 16'd8715;  "prod": cp = 16'd8719;  "sum": cp = 16'd8721;
      "minus": cp = 16'd8722;  "lowast": cp = 16'd8727;  "radic": cp = 16'd8730;
      "prop": cp = 16'd8733;  "infin": cp = 16'd8734;  "ang": cp = 16'd8736;
      "and": cp = 16'd8743;  "or": cp = 16'd8744;  "cap": cp = 16'd8745;
      "cup": cp = 16'd8746;  "int": cp = 16'd8747;  "there4": cp = 16'd8756;
      "sim": cp = 16'd8764;  "cong": cp = 16'd8773;  "asymp": cp = 16'd8776;
      "ne": cp = 16'd8800;  "equiv": cp = 16'd8801;  "le": cp = 16'd8804;
      "ge": cp = 16'd8805;  "sub": cp = 16'd8834;  "sup": cp = 16'd8835;
      "nsub": cp = 16'd8836;  "sube": cp = 16'd8838;  "supe": cp = 16'd8839;
      "oplus": cp = 16'd8853;  "otimes": cp = 16'd8855;  "perp": cp = 16'd8869;
      "sdot": cp = 16'd8901;  "Alpha": cp = 16'd913;  "Beta": cp = 16'd914;
      "Gamma": cp = 16'd915;  "Delta": cp = 16'd916;  "Epsilon": cp = 16'd917;
      "Zeta": cp = 16'd918;  "Eta": cp = 16'd919;  "Theta": cp = 16'd920;
      "Iota": cp = 16'd921;  "Kappa": cp = 16'd922;  "Lambda": cp = 16'd923;
      "Mu": cp = 16'd924;  "Nu": cp = 16'd925;  "Xi": cp = 16'd926;
      "Omicron": cp = 16'd927;  "Pi": cp = 16'd928;  "Rho": cp = 16'd929;
      "Sigma": cp = 16'd931;  "Tau": cp = 16'd932;  "Upsilon": cp = 16'd933;
      "Phi": cp = 16'd934;  "Chi": cp = 16'd935;  "Psi": cp = 16'd936;
      "Omega": cp = 16'd937;  "alpha": cp = 16'd945;  "beta": cp = 16'd946;
      "gamma": cp = 16'd947;  "delta": cp = 16'd948;  "epsilon": cp = 16'd949;
      "zeta": cp = 16'd950;  "eta": cp = 16'd951;  "theta": cp = 16'd952;
      "iota": cp = 16'd953;  "kappa": cp = 16'd954;  "lambda": cp = 16'd955;
      "mu": cp = 16'd956;  "nu": cp = 16'd957;  "xi": cp = 16'd958;
      "omicron": cp = 16'd959;  "pi": cp = 16'd960;  "rho": cp = 16'd961;
      "sigmaf": cp = 16'd962;  "sigma": cp = 16'd963;  "tau": cp = 16'd964;
      "upsilon": cp = 16'd965;  "phi": cp = 16'd966;  "chi": cp = 16'd967;
      "psi": cp = 16'd968;  "omega": cp = 16'd969;  "thetasym": cp = 16'd977;
      "upsih": cp = 16'd978;  "piv": cp = 16'd982;  "OElig": cp = 16'd338;
      "oelig": cp = 16'd339;  "Scaron": cp = 16'd352;  "scaron": cp = 16'd353;
      "Yuml": cp = 16'd376;  "fnof": cp = 16'd402;  "circ": cp = 16'd710;
      "tilde": cp = 16'd732;  "ensp": cp = 16'd8194;  "emsp": cp = 16'd8195;
      "thinsp": cp = 16'd8201;  "zwnj": cp = 16'd8204;  "zwj": cp = 16'd8205;
      "lrm": cp = 16'd8206;  "rlm": cp = 16'd8207;  "ndash": cp = 16'd8211;
      "mdash": cp = 16'd8212;  "lsquo": cp = 16'd8216;  "rsquo": cp = 16'd8217;
      "sbquo": cp = 16'd8218;  "ldquo": cp = 16'd8220;  "rdquo": cp = 16'd8221;
      "bdquo": cp = 16'd8222;  "dagger": cp = 16'd8224;  "Dagger": cp = 16'd8225;
      "bull": cp = 16'd8226;  "hellip": cp = 16'd8230;  "permil": cp = 16'd8240;
      "prime": cp = 16'd8242;  "Prime": cp = 16'd8243;  "lsaquo": cp = 16'd8249;
      "rsaquo": cp = 16'd8250;  "oline": cp = 16'd8254;  "euro": cp = 16'd8364;
      "trade": cp = 16'd8482;  "larr": cp = 16'd8592;  "uarr": cp = 16'd8593;
      "rarr": cp = 16'd8594;  "darr": cp = 16'd8595;  "harr": cp = 16'd8596;
      "crarr": cp = 16'd8629;  "lceil": cp = 16'd8968;  "rceil": cp = 16'd8969;
      "lfloor": cp = 16'd8970;  "rfloor": cp = 16'd8971;  "loz": cp = 16'd9674;
      "spades": cp = 16'd9824;  "clubs": cp = 16'd9827;  "hearts": cp = 16'd9829;
      "diams": cp = 16'd9830;
      default: cp = 16'd0;
    endcase
    return cp;
  endfunction

endpackage

/* src/hesd_front.sv */
// front end: accepts text beats, tracks the entity candidate, issues commands
module hesd_front import hesd_pkg::*; #(
  parameter int unsigned MaxBody = MAX_BODY_DEF,
  localparam int unsigned Depth  = MaxBody + 1,
  localparam int unsigned IW     = $clog2(Depth),
  localparam int unsigned CW     = $clog2(Depth + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         in_byte_i,
  input  logic               text_end_i,
  input  logic               full_i,
  output logic               cmd_push_o,
  output logic [Depth*8-1:0] cmd_rep_o,
  output logic [CW-1:0]      cmd_cnt_o,
  output cmd_ctl_t           cmd_ctl_o
);

  logic [7:0]  pend_q [Depth];
  logic [CW-1:0] cnt_q, cnt_d;
  logic        coll_q, coll_d;
  logic        num_q, num_d;
  logic        inv_q, inv_d;
  logic [20:0] code_q, code_d;

  logic          accept;
  logic          is_digit, is_letter, ok;
  logic [CW-1:0] pos;
  logic [24:0]   code_nx;
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic [7:0]    wr_data;
  logic [CW-1:0] rep_n;
  tail_kind_e    kind;
  logic [20:0]   val;

  assign accept     = in_valid_i && !full_i;
  assign in_stall_o = full_i;

  assign is_digit  = (in_byte_i >= 8'h30) && (in_byte_i <= 8'h39);
  assign is_letter = ((in_byte_i >= 8'h61) && (in_byte_i <= 8'h7A)) ||
                     ((in_byte_i >= 8'h41) && (in_byte_i <= 8'h5A));
  assign pos       = cnt_q - CW'(1);
  assign code_nx   = ({4'b0, code_q} << 3) + ({4'b0, code_q} << 1) + 25'(in_byte_i[3:0]);

  always_comb begin
    cnt_d   = cnt_q;
    coll_d  = coll_q;
    num_d   = num_q;
    inv_d   = inv_q;
    code_d  = code_q;
    wr_en   = 1'b0;
    wr_idx  = cnt_q[IW-1:0];
    wr_data = in_byte_i;
    rep_n   = '0;
    kind    = TK_NONE;
    val     = '0;
    ok      = 1'b0;
    if (!coll_q) begin
      if (in_byte_i == CH_AMP) begin
        cnt_d   = CW'(1);
        coll_d  = 1'b1;
        wr_en   = 1'b1;
        wr_idx  = '0;
        wr_data = CH_AMP;
      end else begin
        kind = TK_BYTE;
        val  = {13'b0, in_byte_i};
      end
    end else if (in_byte_i == CH_SEMI) begin
      if ((cnt_q >= CW'(3)) && !inv_q && num_q && (code_q != '0) && (code_q <= CODE_LIMIT)) begin
        kind = TK_CODE;
        val  = code_q;
      end else if ((cnt_q >= CW'(3)) && !inv_q && !num_q) begin
        rep_n = cnt_q;
        kind  = TK_NAME;
      end else begin
        rep_n = cnt_q;
        kind  = TK_BYTE;
        val   = {13'b0, CH_SEMI};
      end
      cnt_d  = '0;
      coll_d = 1'b0;
      num_d  = 1'b0;
      inv_d  = 1'b0;
      code_d = '0;
    end else if (in_byte_i == CH_AMP) begin
      rep_n   = cnt_q;
      cnt_d   = CW'(1);
      num_d   = 1'b0;
      inv_d   = 1'b0;
      code_d  = '0;
      wr_en   = 1'b1;
      wr_idx  = '0;
      wr_data = CH_AMP;
    end else begin
      ok = (pos == '0) ? ((in_byte_i == CH_HASH) || is_letter) : (is_digit || is_letter);
      if (!ok || (pos >= CW'(MaxBody))) begin
        rep_n  = cnt_q;
        kind   = TK_BYTE;
        val    = {13'b0, in_byte_i};
        cnt_d  = '0;
        coll_d = 1'b0;
        num_d  = 1'b0;
        inv_d  = 1'b0;
        code_d = '0;
      end else begin
        wr_en = 1'b1;
        cnt_d = cnt_q + CW'(1);
        if (pos == '0) begin
          num_d = (in_byte_i == CH_HASH);
        end else if (num_q) begin
          if (is_letter) begin
            inv_d = 1'b1;
          end else if (code_nx > {4'b0, CODE_LIMIT}) begin
            code_d = CODE_SAT;
          end else begin
            code_d = code_nx[20:0];
          end
        end
      end
    end
    // end of text: flush what is still buffered
    if (text_end_i) begin
      if (coll_d) begin
        if (rep_n == '0) begin
          rep_n = cnt_d;
        end else begin
          kind = TK_BYTE;
          val  = {13'b0, CH_AMP};
        end
      end
      cnt_d  = '0;
      coll_d = 1'b0;
      num_d  = 1'b0;
      inv_d  = 1'b0;
      code_d = '0;
    end
  end

  // snapshot sees the incoming byte at the append slot
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      cmd_rep_o[i*8 +: 8] = (cnt_q == CW'(i)) ? in_byte_i : pend_q[i];
    end
  end

  assign cmd_push_o         = accept && ((kind != TK_NONE) || (rep_n != '0));
  assign cmd_cnt_o          = rep_n;
  assign cmd_ctl_o.kind     = kind;
  assign cmd_ctl_o.val      = val;
  assign cmd_ctl_o.text_end = text_end_i;

  always_ff @(posedge clk_i) begin
    if (accept && wr_en) begin
      pend_q[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      coll_q <= 1'b0;
      num_q  <= 1'b0;
      inv_q  <= 1'b0;
      code_q <= '0;
    end else if (accept) begin
      cnt_q  <= cnt_d;
      coll_q <= coll_d;
      num_q  <= num_d;
      inv_q  <= inv_d;
      code_q <= code_d;
    end
  end

endmodule

/* src/hesd_fifo.sv */
// short command queue between front and back
module hesd_fifo import hesd_pkg::*; #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = FIFO_DEPTH_DEF,
  localparam int unsigned PW   = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned NW   = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             avail_o,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [NW-1:0]    num_q;
  logic             do_push, do_pop;

  assign full_o  = (num_q == NW'(Depth));
  assign avail_o = (num_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && avail_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      num_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PW'(Depth - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(Depth - 1)) ? '0 : rptr_q + PW'(1);
      end
      num_q <= num_q + NW'(do_push) - NW'(do_pop);
    end
  end

endmodule

/* src/hesd_back.sv */
// back end: resolves names and code points, emits one byte per beat
module hesd_back import hesd_pkg::*; #(
  parameter int unsigned MaxBody = MAX_BODY_DEF,
  localparam int unsigned Depth  = MaxBody + 1,
  localparam int unsigned IW     = $clog2(Depth),
  localparam int unsigned CW     = $clog2(Depth + 1),
  localparam int unsigned TW     = $clog2(Depth + 5)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  logic [Depth*8-1:0] head_rep_i,
  input  logic [CW-1:0]      head_cnt_i,
  input  cmd_ctl_t           head_ctl_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               run_last_o,
  output logic               text_done_o
);

  logic [63:0]     key;
  logic [15:0]     name_val;
  utf8_t           enc;
  logic [CW-1:0]   r_cnt;
  logic [3:0][7:0] r_tail;
  logic [2:0]      r_tlen;

  logic               b_valid_q;
  logic [Depth*8-1:0] b_rep_q;
  logic [CW-1:0]      b_cnt_q;
  logic [3:0][7:0]    b_tail_q;
  logic [2:0]         b_tlen_q;
  logic               b_end_q;
  logic [TW-1:0]      b_idx_q;

  logic          out_valid_q;
  logic [7:0]    out_byte_q;
  logic          run_last_q, text_done_q;

  logic          out_ready, emit, b_last, load;
  logic [TW-1:0] total, tidx;
  logic [7:0]    cur_byte;

  always_comb begin
    key = '0;
    for (int i = 1; i <= 8; i++) begin
      if (CW'(i) < head_cnt_i) begin
        key = {key[55:0], head_rep_i[i*8 +: 8]};
      end
    end
  end

  assign name_val = (head_cnt_i <= CW'(9)) ? name_cp(key) : 16'd0;
  assign enc = utf8_enc((head_ctl_i.kind == TK_CODE) ? head_ctl_i.val : {5'b0, name_val});

  always_comb begin
    r_cnt  = head_cnt_i;
    r_tail = '0;
    r_tlen = 3'd0;
    case (head_ctl_i.kind)
      TK_BYTE: begin
        r_tail[0] = head_ctl_i.val[7:0];
        r_tlen    = 3'd1;
      end
      TK_CODE: begin
        r_cnt  = '0;
        r_tail = enc.b;
        r_tlen = enc.len;
      end
      TK_NAME: begin
        if (name_val != 16'd0) begin
          r_cnt  = '0;
          r_tail = enc.b;
          r_tlen = enc.len;
        end else begin
          r_tail[0] = CH_SEMI;
          r_tlen    = 3'd1;
        end
      end
      default: begin
        r_tlen = 3'd0;
      end
    endcase
  end

  assign out_ready = !out_valid_q || !out_stall_i;
  assign emit      = b_valid_q && out_ready;
  assign total     = TW'(b_cnt_q) + TW'(b_tlen_q);
  assign b_last    = (b_idx_q == total - TW'(1));
  assign load      = !b_valid_q || (emit && b_last);
  assign pop_o     = load && head_valid_i;
  assign tidx      = b_idx_q - TW'(b_cnt_q);
  assign cur_byte  = (b_idx_q < TW'(b_cnt_q)) ? b_rep_q[b_idx_q[IW-1:0]*8 +: 8]
                                              : b_tail_q[tidx[1:0]];

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b_rep_q  <= head_rep_i;
      b_cnt_q  <= r_cnt;
      b_tail_q <= r_tail;
      b_tlen_q <= r_tlen;
      b_end_q  <= head_ctl_i.text_end;
    end
    if (emit) begin
      out_byte_q  <= cur_byte;
      run_last_q  <= b_last;
      text_done_q <= b_last && b_end_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      b_idx_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        b_valid_q <= 1'b1;
        b_idx_q   <= '0;
      end else if (emit) begin
        b_valid_q <= !b_last;
        b_idx_q   <= b_idx_q + TW'(1);
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = run_last_q;
  assign text_done_o = text_done_q;

endmodule

/* src/html_entity_stream_decoder.sv */
// top level of the html entity stream decoder
// Text goes in one byte per beat and comes out one byte per beat, with each
// entity of the form &name; or &#digits; replaced by its UTF-8 bytes and
// everything else passed through; a candidate that does not resolve is
// replayed as it came. The front end takes a new byte every cycle while the
// two-entry command queue has room. The emit stage puts out one byte per
// cycle while the output is not stalled, so an input byte that yields n
// output bytes holds the back end until all n are out (n from 1 to
// MaxBody+2; bytes buffered inside a candidate yield nothing until it
// closes). Plain text sustains one byte per cycle without output stalls;
// replays and multi-byte characters are absorbed by the queue and stall the
// input once it is full. Bytes pass the queue, command and output registers.
module html_entity_stream_decoder import hesd_pkg::*; #(
  parameter int unsigned MaxBody = MAX_BODY_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       text_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       text_done_o
);

  localparam int unsigned Depth = MaxBody + 1;
  localparam int unsigned CW    = $clog2(Depth + 1);
  localparam int unsigned QW    = Depth * 8 + CW + $bits(cmd_ctl_t);

  logic               push, full, pop, avail;
  logic [Depth*8-1:0] f_rep, h_rep;
  logic [CW-1:0]      f_cnt, h_cnt;
  cmd_ctl_t           f_ctl, h_ctl;
  logic [QW-1:0]      q_in, q_out;

  hesd_front #(.MaxBody(MaxBody)) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_byte_i,
    .text_end_i,
    .full_i     (full),
    .cmd_push_o (push),
    .cmd_rep_o  (f_rep),
    .cmd_cnt_o  (f_cnt),
    .cmd_ctl_o  (f_ctl)
  );

  assign q_in = {f_rep, f_cnt, f_ctl};

  hesd_fifo #(.Width(QW), .Depth(FIFO_DEPTH_DEF)) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .data_i  (q_in),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .data_o  (q_out)
  );

  assign {h_rep, h_cnt, h_ctl} = q_out;

  hesd_back #(.MaxBody(MaxBody)) u_back (
    .clk_i,
    .rst_ni,
    .head_valid_i (avail),
    .head_rep_i   (h_rep),
    .head_cnt_i   (h_cnt),
    .head_ctl_i   (h_ctl),
    .pop_o        (pop),
    .out_valid_o,
    .out_stall_i,
    .out_byte_o,
    .run_last_o,
    .text_done_o
  );

endmodule
